[hdl/utf8d_pkg.sv]
// ----------------------------------------------------------------------------
// utf8d_pkg
// shared widths, codes, types and byte helpers of the utf-8 decoder
// ----------------------------------------------------------------------------
package utf8d_pkg;

	localparam int MAX_CHARS   = 64;
	localparam int BYTE_W      = 8;
	localparam int CAP_W       = 7;
	localparam int CP_W        = 21;
	localparam int STATUS_W    = 2;
	localparam int CNT_W       = $clog2(MAX_CHARS + 1);
	localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	localparam logic [STATUS_W-1:0] STAT_NONE   = 2'd0;
	localparam logic [STATUS_W-1:0] STAT_KEYSYM = 2'd1;
	localparam logic [STATUS_W-1:0] STAT_CHARS  = 2'd2;
	localparam logic [STATUS_W-1:0] STAT_BOTH   = 2'd3;

	localparam logic [2:0] CLS_SKIP  = 3'd0;
	localparam logic [2:0] CLS_ASCII = 3'd1;
	localparam logic [2:0] CLS_LEAD2 = 3'd2;
	localparam logic [2:0] CLS_LEAD3 = 3'd3;
	localparam logic [2:0] CLS_LEAD4 = 3'd4;

	localparam logic [1:0] LEN_1 = 2'd0;
	localparam logic [1:0] LEN_2 = 2'd1;
	localparam logic [1:0] LEN_3 = 2'd2;
	localparam logic [1:0] LEN_4 = 2'd3;

	typedef struct packed {
		logic [3:0][BYTE_W-1:0] bytes;
		logic [1:0]             len;
		logic                   valid;
	} utf8d_slot_t;

	typedef struct packed {
		utf8d_slot_t         slot_a;
		utf8d_slot_t         slot_b;
		logic                two;
		logic                done;
		logic [STATUS_W-1:0] status;
		logic [CAP_W-1:0]    count;
	} utf8d_op_t;

	function automatic logic [2:0] byte_class(logic [BYTE_W-1:0] b);
		logic [2:0] cls;
		if (b inside {[8'h00:8'h7F]}) cls = CLS_ASCII;
		else if (b inside {[8'hC0:8'hDF]}) cls = CLS_LEAD2;
		else if (b inside {[8'hE0:8'hEF]}) cls = CLS_LEAD3;
		else if (b inside {[8'hF0:8'hF7]}) cls = CLS_LEAD4;
		else cls = CLS_SKIP;
		return cls;
	endfunction

	function automatic logic [1:0] class_len(logic [2:0] cls);
		logic [1:0] len;
		case (cls)
			CLS_LEAD2: len = LEN_2;
			CLS_LEAD3: len = LEN_3;
			CLS_LEAD4: len = LEN_4;
			default:   len = LEN_1;
		endcase
		return len;
	endfunction

	function automatic logic [CP_W-1:0] seq_value(logic [3:0][BYTE_W-1:0] b, logic [1:0] len);
		logic [CP_W-1:0] cp;
		case (len)
			LEN_1:   cp = CP_W'(b[0]);
			LEN_2:   cp = CP_W'({b[0][4:0], b[1][5:0]});
			LEN_3:   cp = CP_W'({b[0][3:0], b[1][5:0], b[2][5:0]});
			default: cp = {b[0][2:0], b[1][5:0], b[2][5:0], b[3][5:0]};
		endcase
		return cp;
	endfunction

endpackage

[hdl/utf8d_text_if.sv]
// ----------------------------------------------------------------------------
// utf8d_text_if
// byte request channel into the decoder
// ----------------------------------------------------------------------------
interface utf8d_text_if;
	import utf8d_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] text_byte;
	logic              byte_present;
	logic              run_end;
	logic              has_keysym;
	logic [CAP_W-1:0]  capacity;

	modport source (
		output valid, text_byte, byte_present, run_end, has_keysym, capacity,
		input  ready
	);

	modport sink (
		input  valid, text_byte, byte_present, run_end, has_keysym, capacity,
		output ready
	);

endinterface

[hdl/utf8d_char_if.sv]
// ----------------------------------------------------------------------------
// utf8d_char_if
// code point request channel out of the decoder
// ----------------------------------------------------------------------------
interface utf8d_char_if;
	import utf8d_pkg::*;

	logic                valid;
	logic                ready;
	logic [CP_W-1:0]     code_point;
	logic                code_valid;
	logic                done_res;
	logic [STATUS_W-1:0] lookup_status;
	logic [CAP_W-1:0]    char_count;

	modport source (
		output valid, code_point, code_valid, done_res, lookup_status, char_count,
		input  ready
	);

	modport sink (
		input  valid, code_point, code_valid, done_res, lookup_status, char_count,
		output ready
	);

endinterface

[hdl/utf8d_front.sv]
// ----------------------------------------------------------------------------
// utf8d_front
// accepts text bytes, tracks open sequences and the run's char count,
// and classifies each byte into queue entries of up to two results
// ----------------------------------------------------------------------------
module utf8d_front (
	input  logic                 clk,
	input  logic                 arst_n,
	utf8d_text_if.sink           text,
	input  logic                 queue_full,
	output logic                 push,
	output utf8d_pkg::utf8d_op_t push_op
);
	import utf8d_pkg::*;

	logic [2:0][BYTE_W-1:0] seq_q, seq_n;
	logic [1:0]             fill_q, fill_n;
	logic [CNT_W-1:0]       wc_q, wc1, wc2, wc3;

	logic [CMP_W-1:0]       cap_ext, cap_eff;
	logic [3:0][BYTE_W-1:0] buf_b;
	logic [2:0]             cls_in, cls_lead, cls_b1, cls_b2;
	logic                   act, accept, complete, cur_emit;
	logic                   r1_ascii, r1_pair, r1_ok, r2_ok, r1_emit, r2_emit;
	utf8d_slot_t            cur, res1, res2;

	assign accept     = text.valid && text.ready;
	assign text.ready = !queue_full;

	always_comb begin
		cap_ext = CMP_W'(text.capacity);
		cap_eff = (cap_ext > CMP_W'(MAX_CHARS)) ? CMP_W'(MAX_CHARS) : cap_ext;
	end

	// current byte against the open sequence
	always_comb begin
		act      = text.byte_present && (CMP_W'(wc_q) < cap_eff);
		cls_in   = byte_class(text.text_byte);
		cls_lead = byte_class(seq_q[0]);
		buf_b    = {{BYTE_W{1'b0}}, seq_q};
		buf_b[fill_q] = text.text_byte;
		seq_n    = seq_q;
		fill_n   = fill_q;
		cur_emit = 1'b0;
		cur      = '0;
		case (cls_lead)
			CLS_LEAD3: complete = (fill_q == 2'd2);
			CLS_LEAD4: complete = (fill_q == 2'd3);
			default:   complete = 1'b1;
		endcase
		if (act) begin
			if (fill_q == 2'd0) begin
				if (cls_in == CLS_ASCII) begin
					cur_emit       = 1'b1;
					cur.bytes      = {{3*BYTE_W{1'b0}}, text.text_byte};
					cur.len        = LEN_1;
					cur.valid      = 1'b1;
				end else if (cls_in != CLS_SKIP) begin
					seq_n[0] = text.text_byte;
					fill_n   = 2'd1;
				end
			end else if (complete) begin
				cur_emit  = 1'b1;
				cur.bytes = buf_b;
				cur.len   = class_len(cls_lead);
				cur.valid = 1'b1;
				fill_n    = 2'd0;
			end else begin
				seq_n[fill_q] = text.text_byte;
				fill_n        = fill_q + 2'd1;
			end
		end
		wc1 = wc_q + CNT_W'(cur_emit);
	end

	// run end: drop the cut lead and decode what followed it
	always_comb begin
		cls_b1   = byte_class(seq_n[1]);
		cls_b2   = byte_class(seq_n[2]);
		r1_ascii = (fill_n >= 2'd2) && (cls_b1 == CLS_ASCII);
		r1_pair  = (fill_n == 2'd3) && (cls_b1 == CLS_LEAD2);
		r1_ok    = r1_ascii || r1_pair;
		r2_ok    = (fill_n == 2'd3) && (cls_b2 == CLS_ASCII) && !r1_pair;
		r1_emit  = text.run_end && r1_ok && (CMP_W'(wc1) < cap_eff);
		wc2      = wc1 + CNT_W'(r1_emit);
		r2_emit  = text.run_end && r2_ok && (CMP_W'(wc2) < cap_eff);
		wc3      = wc2 + CNT_W'(r2_emit);
		res1       = '0;
		res1.bytes = {{2*BYTE_W{1'b0}}, seq_n[2], seq_n[1]};
		res1.len   = r1_pair ? LEN_2 : LEN_1;
		res1.valid = 1'b1;
		res2       = '0;
		res2.bytes = {{3*BYTE_W{1'b0}}, seq_n[2]};
		res2.len   = LEN_1;
		res2.valid = 1'b1;
	end

	always_comb begin
		push_op = '0;
		if (cur_emit) push_op.slot_a = cur;
		else if (r1_emit) push_op.slot_a = res1;
		else if (r2_emit) push_op.slot_a = res2;
		push_op.slot_b = res2;
		push_op.two    = r1_emit && r2_emit;
		push_op.done   = text.run_end;
		push_op.count  = CAP_W'(wc3);
		if (wc3 != '0) push_op.status = text.has_keysym ? STAT_BOTH : STAT_CHARS;
		else push_op.status = text.has_keysym ? STAT_KEYSYM : STAT_NONE;
		push = accept && (cur_emit || text.run_end);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q  <= '0;
			fill_q <= '0;
			wc_q   <= '0;
		end else if (accept) begin
			if (text.run_end) begin
				seq_q  <= '0;
				fill_q <= '0;
				wc_q   <= '0;
			end else begin
				seq_q  <= seq_n;
				fill_q <= fill_n;
				wc_q   <= wc1;
			end
		end
	end

endmodule

[hdl/utf8d_queue.sv]
// ----------------------------------------------------------------------------
// utf8d_queue
// short fifo of classified entries between front and back
// ----------------------------------------------------------------------------
module utf8d_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  utf8d_pkg::utf8d_op_t push_op,
	output logic                 full,
	input  logic                 pop,
	output utf8d_pkg::utf8d_op_t head_op,
	output logic                 empty
);
	import utf8d_pkg::*;

	utf8d_op_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full    = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty   = (count_q == '0);
	assign head_op = entry_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk) begin
		if (do_push) entry_q[wr_ptr_q] <= push_op;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop) rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			count_q <= count_q + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
		end
	end

endmodule

[hdl/utf8d_back.sv]
// ----------------------------------------------------------------------------
// utf8d_back
// assembles code points from queue entries and sends them one per cycle
// through the output register while the queue holds entries and chars is ready
// ----------------------------------------------------------------------------
module utf8d_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  utf8d_pkg::utf8d_op_t head_op,
	input  logic                 head_valid,
	output logic                 pop,
	utf8d_char_if.source         chars
);
	import utf8d_pkg::*;

	logic                phase_q;
	logic                valid_q;
	logic [CP_W-1:0]     cp_q;
	logic                code_valid_q, done_q;
	logic [STATUS_W-1:0] status_q;
	logic [CAP_W-1:0]    count_q;
	utf8d_slot_t         sel;
	logic                last, load;

	assign sel  = phase_q ? head_op.slot_b : head_op.slot_a;
	assign last = !head_op.two || phase_q;
	assign load = head_valid && (!valid_q || chars.ready);
	assign pop  = load && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			phase_q <= 1'b0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				phase_q <= !last;
			end else if (chars.ready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			cp_q         <= sel.valid ? seq_value(sel.bytes, sel.len) : '0;
			code_valid_q <= sel.valid;
			done_q       <= last && head_op.done;
			status_q     <= (last && head_op.done) ? head_op.status : STAT_NONE;
			count_q      <= (last && head_op.done) ? head_op.count : '0;
		end
	end

	assign chars.valid         = valid_q;
	assign chars.code_point    = cp_q;
	assign chars.code_valid    = code_valid_q;
	assign chars.done_res      = done_q;
	assign chars.lookup_status = status_q;
	assign chars.char_count    = count_q;

endmodule

[hdl/utf8_to_codepoint_decoder_core.sv]
// ----------------------------------------------------------------------------
// utf8_to_codepoint_decoder_core
// lenient utf-8 to code point decoder for key event text
//
//   channel | side   | request                        | handshake
//   text    | sink   | one text byte with run info    | valid/ready
//   chars   | source | one code point or done marker  | valid/ready
//
// one byte is taken per cycle while the queue is not full
// a run end that yields two code points sends them as two results on the chars side
// results pass from the front through the queue and the output register to chars
// reset clears the open sequence, the run count, the queue and the output
// a chars stall fills the four-entry queue before text is held off
// ----------------------------------------------------------------------------
module utf8_to_codepoint_decoder_core (
	input  logic         clk,
	input  logic         arst_n,
	utf8d_text_if.sink   text,
	utf8d_char_if.source chars
);
	import utf8d_pkg::*;

	utf8d_op_t push_op, head_op;
	logic      push, q_full, q_empty, pop;

	utf8d_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text       (text),
		.queue_full (q_full),
		.push       (push),
		.push_op    (push_op)
	);

	utf8d_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_op (push_op),
		.full    (q_full),
		.pop     (pop),
		.head_op (head_op),
		.empty   (q_empty)
	);

	utf8d_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_op    (head_op),
		.head_valid (!q_empty),
		.pop        (pop),
		.chars      (chars)
	);

	// a result without a character only appears as the done marker
	assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && !chars.code_valid |-> chars.done_res && chars.code_point == '0)
		else $error("empty result outside done");

	// results before the done marker carry no status or count
	assert property (@(posedge clk) disable iff (!arst_n)
		chars.valid && !chars.done_res |-> chars.lookup_status == STAT_NONE &&
			chars.char_count == '0)
		else $error("status on non-final result");

	// a two-result entry at the head is only retired on its second result
	assert property (@(posedge clk) disable iff (!arst_n)
		pop && head_op.two |-> $past(!q_empty) && $past(!pop || !head_op.two) ||
			$past(q_empty) || !$past(head_op.two) || $past(pop))
		else $error("two-result entry retired early");

	// the queue is never written while full
	assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !q_full)
		else $error("queue overrun");

endmodule
